// File: rtl/core/rrts_pkg.sv
// Shared types, codes and microcode for the round-robin task scheduler.
// Holds the control word layout, the step program and the command decode.
// No dependencies.
package rrts_pkg;

	localparam int MAX_TASKS_DEF = 8;

	localparam int FUNC_W   = 3;
	localparam int ID_W     = 3;
	localparam int STATUS_W = 3;
	localparam int QCOUNT_W = 4;

	localparam logic [FUNC_W-1:0] FN_REG     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DISPATCH = 3'd1;
	localparam logic [FUNC_W-1:0] FN_YIELD   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_BLOCK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_UNBLOCK = 3'd4;
	localparam logic [FUNC_W-1:0] FN_TERM    = 3'd5;

	localparam logic [2:0] TS_READY      = 3'd1;
	localparam logic [2:0] TS_RUNNING    = 3'd2;
	localparam logic [2:0] TS_BLOCKED    = 3'd3;
	localparam logic [2:0] TS_TERMINATED = 3'd4;

	localparam logic [STATUS_W-1:0] RS_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] RS_IDLE    = 3'd1;
	localparam logic [STATUS_W-1:0] RS_ALLDONE = 3'd2;
	localparam logic [STATUS_W-1:0] RS_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] RS_NORUN   = 3'd4;
	localparam logic [STATUS_W-1:0] RS_BUSY    = 3'd5;
	localparam logic [STATUS_W-1:0] RS_NOCHG   = 3'd6;

	typedef logic [3:0] act_t;
	localparam act_t A_NOP     = 4'd0;
	localparam act_t A_IDLE    = 4'd1;
	localparam act_t A_RET     = 4'd2;
	localparam act_t A_REG     = 4'd3;
	localparam act_t A_POP     = 4'd4;
	localparam act_t A_YIELD   = 4'd5;
	localparam act_t A_BLOCK   = 4'd6;
	localparam act_t A_UNBLK   = 4'd7;
	localparam act_t A_CLRIDX  = 4'd8;
	localparam act_t A_RELEASE = 4'd9;
	localparam act_t A_INC     = 4'd10;
	localparam act_t A_TERM    = 4'd11;

	typedef logic [1:0] idsel_t;
	localparam idsel_t ID_ZERO = 2'd0;
	localparam idsel_t ID_Q    = 2'd1;
	localparam idsel_t ID_RUN  = 2'd2;
	localparam idsel_t ID_TGT  = 2'd3;

	localparam int NCOND = 16;
	typedef logic [3:0] cnd_t;
	localparam cnd_t C_ALWAYS  = 4'd0;
	localparam cnd_t C_NEVER   = 4'd1;
	localparam cnd_t C_FULL    = 4'd2;
	localparam cnd_t C_RUN     = 4'd3;
	localparam cnd_t C_NOALIVE = 4'd4;
	localparam cnd_t C_EMPTY   = 4'd5;
	localparam cnd_t C_NORUN   = 4'd6;
	localparam cnd_t C_TGTBAD  = 4'd7;
	localparam cnd_t C_NOTBLK  = 4'd8;
	localparam cnd_t C_SCANEND = 4'd9;
	localparam cnd_t C_SKIP    = 4'd10;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;
	localparam pc_t P_IDLE     = 5'd0;
	localparam pc_t P_R_OK     = 5'd1;
	localparam pc_t P_R_FULL   = 5'd2;
	localparam pc_t P_R_IDLE   = 5'd3;
	localparam pc_t P_R_ALL    = 5'd4;
	localparam pc_t P_R_NORUN  = 5'd5;
	localparam pc_t P_R_BUSY   = 5'd6;
	localparam pc_t P_R_NOCHGT = 5'd7;
	localparam pc_t P_R_NOCHGZ = 5'd8;
	localparam pc_t P_REG0     = 5'd9;
	localparam pc_t P_REG1     = 5'd10;
	localparam pc_t P_DSP0     = 5'd11;
	localparam pc_t P_DSP1     = 5'd12;
	localparam pc_t P_DSP2     = 5'd13;
	localparam pc_t P_DSP3     = 5'd14;
	localparam pc_t P_Y0       = 5'd15;
	localparam pc_t P_Y1       = 5'd16;
	localparam pc_t P_B0       = 5'd17;
	localparam pc_t P_B1       = 5'd18;
	localparam pc_t P_U0       = 5'd19;
	localparam pc_t P_U1       = 5'd20;
	localparam pc_t P_U2       = 5'd21;
	localparam pc_t P_T0       = 5'd22;
	localparam pc_t P_T1       = 5'd23;
	localparam pc_t P_T2       = 5'd24;
	localparam pc_t P_T3       = 5'd25;
	localparam pc_t P_TINC     = 5'd26;
	localparam pc_t P_T4       = 5'd27;

	typedef struct packed {
		act_t                act;
		logic                rd_idx;
		logic [STATUS_W-1:0] st;
		idsel_t              idsel;
		cnd_t                cnd;
		pc_t                 jmp;
	} ctl_t;

	function automatic ctl_t cw(input act_t act, input logic rd_idx,
			input logic [STATUS_W-1:0] st, input idsel_t idsel, input cnd_t cnd,
			input pc_t jmp);
		ctl_t c;
		c.act    = act;
		c.rd_idx = rd_idx;
		c.st     = st;
		c.idsel  = idsel;
		c.cnd    = cnd;
		c.jmp    = jmp;
		return c;
	endfunction

	function automatic ctl_t ucode_rom(input pc_t pc);
		ctl_t c;
		case (pc)
			P_IDLE:     c = cw(A_IDLE,    1'b0, RS_OK,      ID_ZERO, C_NEVER,   P_IDLE);
			P_R_OK:     c = cw(A_RET,     1'b0, RS_OK,      ID_Q,    C_ALWAYS,  P_IDLE);
			P_R_FULL:   c = cw(A_RET,     1'b0, RS_FULL,    ID_ZERO, C_ALWAYS,  P_IDLE);
			P_R_IDLE:   c = cw(A_RET,     1'b0, RS_IDLE,    ID_ZERO, C_ALWAYS,  P_IDLE);
			P_R_ALL:    c = cw(A_RET,     1'b0, RS_ALLDONE, ID_ZERO, C_ALWAYS,  P_IDLE);
			P_R_NORUN:  c = cw(A_RET,     1'b0, RS_NORUN,   ID_ZERO, C_ALWAYS,  P_IDLE);
			P_R_BUSY:   c = cw(A_RET,     1'b0, RS_BUSY,    ID_RUN,  C_ALWAYS,  P_IDLE);
			P_R_NOCHGT: c = cw(A_RET,     1'b0, RS_NOCHG,   ID_TGT,  C_ALWAYS,  P_IDLE);
			P_R_NOCHGZ: c = cw(A_RET,     1'b0, RS_NOCHG,   ID_ZERO, C_ALWAYS,  P_IDLE);
			P_REG0:     c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_FULL,    P_R_FULL);
			P_REG1:     c = cw(A_REG,     1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_R_OK);
			P_DSP0:     c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_RUN,     P_R_BUSY);
			P_DSP1:     c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_NOALIVE, P_R_ALL);
			P_DSP2:     c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_EMPTY,   P_R_IDLE);
			P_DSP3:     c = cw(A_POP,     1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_R_OK);
			P_Y0:       c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_NORUN,   P_R_NORUN);
			P_Y1:       c = cw(A_YIELD,   1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_R_OK);
			P_B0:       c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_NORUN,   P_R_NORUN);
			P_B1:       c = cw(A_BLOCK,   1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_R_OK);
			P_U0:       c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_TGTBAD,  P_R_NOCHGT);
			P_U1:       c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_NOTBLK,  P_R_NOCHGT);
			P_U2:       c = cw(A_UNBLK,   1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_R_OK);
			P_T0:       c = cw(A_CLRIDX,  1'b1, RS_OK,      ID_ZERO, C_NORUN,   P_R_NORUN);
			P_T1:       c = cw(A_NOP,     1'b1, RS_OK,      ID_ZERO, C_SCANEND, P_T4);
			P_T2:       c = cw(A_NOP,     1'b1, RS_OK,      ID_ZERO, C_SKIP,    P_TINC);
			P_T3:       c = cw(A_RELEASE, 1'b1, RS_OK,      ID_ZERO, C_NEVER,   P_TINC);
			P_TINC:     c = cw(A_INC,     1'b1, RS_OK,      ID_ZERO, C_ALWAYS,  P_T1);
			P_T4:       c = cw(A_TERM,    1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_R_OK);
			default:    c = cw(A_NOP,     1'b0, RS_OK,      ID_ZERO, C_ALWAYS,  P_IDLE);
		endcase
		return c;
	endfunction

	function automatic pc_t entry_of(input logic [FUNC_W-1:0] func);
		pc_t p;
		case (func)
			FN_REG:      p = P_REG0;
			FN_DISPATCH: p = P_DSP0;
			FN_YIELD:    p = P_Y0;
			FN_BLOCK:    p = P_B0;
			FN_UNBLOCK:  p = P_U0;
			FN_TERM:     p = P_T0;
			default:     p = P_R_NOCHGZ;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/rrts_if.sv
// Command and result channel interfaces of the task scheduler.
// Depends on rrts_pkg for field widths.
interface rrts_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [rrts_pkg::FUNC_W-1:0] func;
	logic [rrts_pkg::ID_W-1:0]   target;

	modport source (output valid, output func, output target, input ready);
	modport sink (input valid, input func, input target, output ready);
endinterface

interface rrts_res_if;
	logic                          valid;
	logic                          ready;
	logic [rrts_pkg::ID_W-1:0]     task_id;
	logic [rrts_pkg::STATUS_W-1:0] status;
	logic [rrts_pkg::QCOUNT_W-1:0] queue_count;
	logic                          running_valid;

	modport source (output valid, output task_id, output status, output queue_count,
		output running_valid, input ready);
	modport sink (input valid, input task_id, input status, input queue_count,
		input running_valid, output ready);
endinterface

// File: rtl/core/rrts_seq.sv
// Microcode sequencer of the task scheduler: step counter, program ROM, jumps.
// Depends on rrts_pkg for the control word and the program.
module rrts_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic [rrts_pkg::FUNC_W-1:0] func,
	input  logic [rrts_pkg::NCOND-1:0]  cond,
	input  logic                        ret_free,
	output rrts_pkg::ctl_t              ctl
);

	rrts_pkg::pc_t pc_q;

	assign ctl = rrts_pkg::ucode_rom(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rrts_pkg::P_IDLE;
		end else begin
			case (ctl.act)
				rrts_pkg::A_IDLE: begin
					if (in_fire)
						pc_q <= rrts_pkg::entry_of(func);
				end
				rrts_pkg::A_RET: begin
					if (ret_free)
						pc_q <= ctl.jmp;
				end
				default: begin
					pc_q <= cond[ctl.cnd] ? ctl.jmp : pc_q + 1'b1;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/round_robin_task_scheduler_unit.sv
// Round-robin task scheduler: task table, ready FIFO, running register.
// Depends on rrts_pkg, rrts_cmd_if, rrts_res_if and rrts_seq.
//
// Usage:
//   cmd carries one command per transaction (func, target); res returns exactly
//   one result per command (task_id, status, queue_count, running_valid).
//   Commands are processed one at a time by a microcoded sequencer; cmd.ready
//   is high only while the sequencer sits in its idle step.
//   Each command steps through its own microcode program, which ends early when
//   the command is refused; terminate, when a task runs, scans every registered
//   id and releases each blocked task other than the running one.
//   After the result is loaded, the sequencer returns to its idle step and
//   accepts the next command; the terminate scan is the longest command.
//   The result sits in an output register; a new command is accepted while it
//   waits. If res stalls, the sequencer holds at its final step until the
//   output register frees up.
//   Reset clears the task count, queue pointers and running flag. Table and
//   queue entries need no clearing: a table entry is read only below the
//   task count, a queue entry only below the fill count.
module round_robin_task_scheduler_unit #(
	parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rrts_cmd_if.sink  cmd,
	rrts_res_if.source res
);

	localparam int IW  = $clog2(MAX_TASKS);
	localparam int CW  = $clog2(MAX_TASKS + 1);
	localparam int CW1 = CW + 1;
	localparam int XW  = (CW > rrts_pkg::ID_W) ? CW : rrts_pkg::ID_W;
	localparam int IDW = (IW > rrts_pkg::ID_W) ? IW : rrts_pkg::ID_W;
	localparam int QW  = (CW > rrts_pkg::QCOUNT_W) ? CW : rrts_pkg::QCOUNT_W;

	rrts_pkg::ctl_t ctl;
	logic [rrts_pkg::NCOND-1:0] cond;
	logic in_fire, ret_free, ret_load;

	logic [CW-1:0] task_count_q, alive_q, fcount_q, idx_q;
	logic [IW-1:0] head_q, tail_q, run_id_q;
	logic          run_flag_q, ov_q;

	logic [rrts_pkg::ID_W-1:0] tgt_q;
	logic [IW-1:0] id_q;
	logic [2:0]    sdata_q;
	logic [IW-1:0] fdata_q;

	logic [2:0]    stat_mem [MAX_TASKS];
	logic [IW-1:0] fifo_mem [MAX_TASKS];

	logic [rrts_pkg::ID_W-1:0]     res_id_q;
	logic [rrts_pkg::STATUS_W-1:0] res_st_q;
	logic [rrts_pkg::QCOUNT_W-1:0] res_qc_q;
	logic                          res_rv_q;

	logic [XW-1:0]  tgt_x;
	logic [IW-1:0]  tgt_id, tc_id, rd_addr;
	logic [IDW-1:0] id_x, run_x;
	logic [QW-1:0]  q_x;
	logic [rrts_pkg::ID_W-1:0] ret_id;

	logic          sw_en, push_en, push_ok, pop;
	logic [IW-1:0] sw_addr, push_id;
	logic [2:0]    sw_data;

	rrts_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.func     (cmd.func),
		.cond     (cond),
		.ret_free (ret_free),
		.ctl      (ctl)
	);

	assign cmd.ready = (ctl.act == rrts_pkg::A_IDLE);
	assign in_fire   = cmd.valid && cmd.ready;
	assign ret_free  = !ov_q || res.ready;
	assign ret_load  = (ctl.act == rrts_pkg::A_RET) && ret_free;

	assign tgt_x   = XW'(tgt_q);
	assign tgt_id  = tgt_x[IW-1:0];
	assign tc_id   = task_count_q[IW-1:0];
	assign rd_addr = ctl.rd_idx ? idx_q[IW-1:0] : tgt_id;
	assign id_x    = IDW'(id_q);
	assign run_x   = IDW'(run_id_q);
	assign q_x     = QW'(fcount_q);

	always_comb begin
		cond = '0;
		cond[rrts_pkg::C_ALWAYS]  = 1'b1;
		cond[rrts_pkg::C_NEVER]   = 1'b0;
		cond[rrts_pkg::C_FULL]    = task_count_q >= CW'(MAX_TASKS);
		cond[rrts_pkg::C_RUN]     = run_flag_q;
		cond[rrts_pkg::C_NOALIVE] = (alive_q == '0);
		cond[rrts_pkg::C_EMPTY]   = (fcount_q == '0);
		cond[rrts_pkg::C_NORUN]   = !run_flag_q;
		cond[rrts_pkg::C_TGTBAD]  = tgt_x >= XW'(task_count_q);
		cond[rrts_pkg::C_NOTBLK]  = (sdata_q != rrts_pkg::TS_BLOCKED);
		cond[rrts_pkg::C_SCANEND] = idx_q >= task_count_q;
		cond[rrts_pkg::C_SKIP]    = (idx_q == CW'(run_id_q)) ||
			(sdata_q != rrts_pkg::TS_BLOCKED);
	end

	always_comb begin
		sw_en   = 1'b0;
		sw_addr = run_id_q;
		sw_data = rrts_pkg::TS_READY;
		push_en = 1'b0;
		push_id = run_id_q;
		pop     = 1'b0;
		case (ctl.act)
			rrts_pkg::A_REG: begin
				sw_en   = 1'b1;
				sw_addr = tc_id;
				push_en = 1'b1;
				push_id = tc_id;
			end
			rrts_pkg::A_POP: begin
				sw_en   = 1'b1;
				sw_addr = fdata_q;
				sw_data = rrts_pkg::TS_RUNNING;
				pop     = 1'b1;
			end
			rrts_pkg::A_YIELD: begin
				sw_en   = 1'b1;
				push_en = 1'b1;
			end
			rrts_pkg::A_BLOCK: begin
				sw_en   = 1'b1;
				sw_data = rrts_pkg::TS_BLOCKED;
			end
			rrts_pkg::A_UNBLK: begin
				sw_en   = 1'b1;
				sw_addr = tgt_id;
				push_en = 1'b1;
				push_id = tgt_id;
			end
			rrts_pkg::A_RELEASE: begin
				sw_en   = 1'b1;
				sw_addr = idx_q[IW-1:0];
				push_en = 1'b1;
				push_id = idx_q[IW-1:0];
			end
			rrts_pkg::A_TERM: begin
				sw_en   = 1'b1;
				sw_data = rrts_pkg::TS_TERMINATED;
			end
			default: begin
				sw_en = 1'b0;
			end
		endcase
		push_ok = push_en && (fcount_q < CW'(MAX_TASKS));
	end

	always_comb begin
		case (ctl.idsel)
			rrts_pkg::ID_ZERO: ret_id = '0;
			rrts_pkg::ID_Q:    ret_id = id_x[rrts_pkg::ID_W-1:0];
			rrts_pkg::ID_RUN:  ret_id = run_x[rrts_pkg::ID_W-1:0];
			rrts_pkg::ID_TGT:  ret_id = tgt_q;
			default:           ret_id = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			alive_q      <= '0;
			fcount_q     <= '0;
			idx_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			run_id_q     <= '0;
			run_flag_q   <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			if (push_ok)
				tail_q <= (tail_q == IW'(MAX_TASKS - 1)) ? '0 : tail_q + 1'b1;
			if (pop) begin
				head_q   <= (head_q == IW'(MAX_TASKS - 1)) ? '0 : head_q + 1'b1;
				fcount_q <= fcount_q - 1'b1;
			end else if (push_ok) begin
				fcount_q <= fcount_q + 1'b1;
			end
			case (ctl.act)
				rrts_pkg::A_REG: begin
					task_count_q <= task_count_q + 1'b1;
					alive_q      <= alive_q + 1'b1;
				end
				rrts_pkg::A_POP: begin
					run_id_q   <= fdata_q;
					run_flag_q <= 1'b1;
				end
				rrts_pkg::A_YIELD, rrts_pkg::A_BLOCK: begin
					run_flag_q <= 1'b0;
				end
				rrts_pkg::A_TERM: begin
					run_flag_q <= 1'b0;
					alive_q    <= alive_q - 1'b1;
				end
				rrts_pkg::A_CLRIDX: begin
					idx_q <= '0;
				end
				rrts_pkg::A_INC: begin
					idx_q <= idx_q + 1'b1;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
			if (ret_load)
				ov_q <= 1'b1;
			else if (res.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			tgt_q <= cmd.target;
		case (ctl.act)
			rrts_pkg::A_REG:   id_q <= tc_id;
			rrts_pkg::A_POP:   id_q <= fdata_q;
			rrts_pkg::A_UNBLK: id_q <= tgt_id;
			rrts_pkg::A_YIELD, rrts_pkg::A_BLOCK, rrts_pkg::A_TERM: id_q <= run_id_q;
			default:           id_q <= id_q;
		endcase
		if (ret_load) begin
			res_id_q <= ret_id;
			res_st_q <= ctl.st;
			res_qc_q <= q_x[rrts_pkg::QCOUNT_W-1:0];
			res_rv_q <= run_flag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sw_en)
			stat_mem[sw_addr] <= sw_data;
		if (push_ok)
			fifo_mem[tail_q] <= push_id;
		sdata_q <= stat_mem[rd_addr];
		fdata_q <= fifo_mem[head_q];
	end

	assign res.valid         = ov_q;
	assign res.task_id       = res_id_q;
	assign res.status        = res_st_q;
	assign res.queue_count   = res_qc_q;
	assign res.running_valid = res_rv_q;

`ifndef SYNTHESIS
	a_alive_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		alive_q <= task_count_q)
		else $error("live task count exceeds registered count");

	a_queue_le_alive: assert property (@(posedge clk) disable iff (!arst_n)
		CW1'(fcount_q) + CW1'(run_flag_q) <= CW1'(alive_q))
		else $error("queued plus running tasks exceed live tasks");

	a_run_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(run_flag_q) |-> $past(ctl.act == rrts_pkg::A_POP))
		else $error("running flag set without a dispatch");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> task_count_q >= $past(task_count_q))
		else $error("task count decreased");
`endif

endmodule
